FILE: hw/rtl/pidfd_pkg.sv
package pidfd_pkg;

  localparam int SampleW  = 16;
  localparam int FracW    = 16;
  localparam int ErrW     = SampleW + 1;
  localparam int ErrSumW  = ErrW + 1;
  localparam int GainW    = 24;
  localparam int PoleW    = 17;
  localparam int TermW    = SampleW + FracW;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = GainW;
  localparam int WideW    = 50;

  localparam int InDataW  = 2 * SampleW;
  localparam int OutDataW = 24;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DERIV_POLE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_MIN    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_MAX    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MODE_BITS  = 3'd6;

  // mode bit positions
  localparam int MODE_ANTI_WINDUP = 0;
  localparam int MODE_INVERT      = 1;

  localparam logic signed [WideW-1:0] TermMax =
    {{(WideW-TermW+1){1'b0}}, {(TermW-1){1'b1}}};
  localparam logic signed [WideW-1:0] TermMin =
    {{(WideW-TermW+1){1'b1}}, {(TermW-1){1'b0}}};

  typedef struct packed {
    logic signed [GainW-1:0]   prop_gain;
    logic signed [GainW-1:0]   integ_gain;
    logic signed [GainW-1:0]   deriv_gain;
    logic signed [PoleW-1:0]   deriv_pole;
    logic signed [SampleW-1:0] out_min;
    logic signed [SampleW-1:0] out_max;
    logic [ModeW-1:0]          mode_bits;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  prev_error;
    logic signed [TermW-1:0] integ_term;
    logic signed [TermW-1:0] deriv_term;
    logic                    last_clamped;
  } state_t;

  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [TermW-1:0] p_term;
    logic signed [TermW-1:0] i_term;
    logic signed [TermW-1:0] d_term;
  } terms_t;

  function automatic logic signed [TermW-1:0] sat32(input logic signed [WideW-1:0] x);
    logic signed [TermW-1:0] r;
    if (x > TermMax) begin
      r = TermMax[TermW-1:0];
    end else if (x < TermMin) begin
      r = TermMin[TermW-1:0];
    end else begin
      r = x[TermW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/pidfd_terms.sv
module pidfd_terms (
  input  logic signed [pidfd_pkg::SampleW-1:0] setpoint,
  input  logic signed [pidfd_pkg::SampleW-1:0] feedback,
  input  pidfd_pkg::cfg_t                      cfg,
  input  pidfd_pkg::state_t                    st,
  output pidfd_pkg::terms_t                    terms
);
  import pidfd_pkg::*;

  logic signed [ErrW-1:0]          err;
  logic signed [ErrSumW-1:0]       err_sum;
  logic signed [ErrSumW-1:0]       err_diff;
  logic signed [GainW+ErrW-1:0]    p_prod;
  logic signed [GainW+ErrSumW-1:0] i_prod;
  logic signed [GainW+ErrSumW-1:0] d_prod;
  logic signed [PoleW+TermW-1:0]   pole_prod;
  logic signed [PoleW+TermW-FracW-1:0] pole_floor;
  logic signed [WideW-1:0]         i_wide;
  logic signed [WideW-1:0]         d_wide;

  always_comb begin
    if (cfg.mode_bits[MODE_INVERT]) begin
      err = ErrW'(feedback) - ErrW'(setpoint);
    end else begin
      err = ErrW'(setpoint) - ErrW'(feedback);
    end
  end

  assign err_sum  = ErrSumW'(err) + ErrSumW'(st.prev_error);
  assign err_diff = ErrSumW'(err) - ErrSumW'(st.prev_error);

  assign p_prod    = cfg.prop_gain * err;
  assign i_prod    = cfg.integ_gain * err_sum;
  assign d_prod    = cfg.deriv_gain * err_diff;
  assign pole_prod = cfg.deriv_pole * st.deriv_term;

  // arithmetic shift rounds toward minus infinity
  assign pole_floor = pole_prod[PoleW+TermW-1:FracW];

  assign i_wide = WideW'(st.integ_term) + WideW'(i_prod);
  assign d_wide = WideW'(d_prod) + WideW'(pole_floor);

  always_comb begin
    terms.err    = err;
    terms.p_term = sat32(WideW'(p_prod));
    if (cfg.mode_bits[MODE_ANTI_WINDUP] && st.last_clamped) begin
      terms.i_term = '0;
    end else begin
      terms.i_term = sat32(i_wide);
    end
    terms.d_term = sat32(d_wide);
  end

endmodule

FILE: hw/rtl/pidfd_clamp.sv
module pidfd_clamp (
  input  pidfd_pkg::terms_t                    terms,
  input  logic signed [pidfd_pkg::SampleW-1:0] out_min,
  input  logic signed [pidfd_pkg::SampleW-1:0] out_max,
  output logic signed [pidfd_pkg::SampleW-1:0] drive,
  output logic                                 clamped
);
  import pidfd_pkg::*;

  logic signed [WideW-1:0] sum_wide;
  logic signed [TermW-1:0] sum;
  logic signed [TermW-1:0] hi;
  logic signed [TermW-1:0] lo;

  assign sum_wide = WideW'(terms.p_term) + WideW'(terms.i_term) + WideW'(terms.d_term);
  assign sum      = sat32(sum_wide);
  assign hi       = {out_max, {FracW{1'b0}}};
  assign lo       = {out_min, {FracW{1'b0}}};

  // upper limit wins when the limits are crossed
  always_comb begin
    if (sum >= hi) begin
      drive   = out_max;
      clamped = (sum != hi);
    end else if (sum <= lo) begin
      drive   = out_min;
      clamped = (sum != lo);
    end else begin
      drive   = sum[TermW-1:FracW];
      clamped = 1'b0;
    end
  end

endmodule

FILE: hw/rtl/pid_filtered_derivative_clamped.sv
// PID controller with filtered derivative and output clamp. Each beat on the
// input carries a setpoint and a feedback sample; each produces exactly one
// output beat with the clamped drive value and a flag telling whether the
// limits cut the sum. The block takes one sample per clock while the output
// is not held back by out_tready: a sample waits in the input register while
// a single combinational pass forms the three terms (four multipliers in
// parallel, the widest 17x32 for the derivative pole) and the clamp, and lands
// in the output register; the integrator, derivative and clamp state are
// updated in the same cycle as the output register is loaded. The output
// register lets a new sample in while a result still waits. Configuration
// registers should only be written while no sample is in flight.
module pid_filtered_derivative_clamped (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // setpoint [15:0], feedback [31:16]
  input  logic [pidfd_pkg::InDataW-1:0]        in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // drive [15:0], clamped [16], zero [23:17]
  output logic [pidfd_pkg::OutDataW-1:0]       out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidfd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pidfd_pkg::CfgDataW-1:0]       cfg_data
);
  import pidfd_pkg::*;

  cfg_t   cfg_r;
  state_t st_r;
  state_t st_nxt;
  terms_t terms;

  logic                       in_valid_r;
  logic                       in_valid_nxt;
  logic signed [SampleW-1:0]  sp_r;
  logic signed [SampleW-1:0]  fb_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic signed [SampleW-1:0]  drive_r;
  logic                       clamped_r;
  logic signed [SampleW-1:0]  drive;
  logic                       clamped;
  logic                       out_free;
  logic                       advance;
  logic                       in_beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain  <= '0;
      cfg_r.integ_gain <= '0;
      cfg_r.deriv_gain <= '0;
      cfg_r.deriv_pole <= '0;
      cfg_r.out_min    <= {1'b1, {(SampleW-1){1'b0}}};
      cfg_r.out_max    <= {1'b0, {(SampleW-1){1'b1}}};
      cfg_r.mode_bits  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:  cfg_r.prop_gain  <= cfg_data[GainW-1:0];
        REG_INTEG_GAIN: cfg_r.integ_gain <= cfg_data[GainW-1:0];
        REG_DERIV_GAIN: cfg_r.deriv_gain <= cfg_data[GainW-1:0];
        REG_DERIV_POLE: cfg_r.deriv_pole <= cfg_data[PoleW-1:0];
        REG_OUT_MIN:    cfg_r.out_min    <= cfg_data[SampleW-1:0];
        REG_OUT_MAX:    cfg_r.out_max    <= cfg_data[SampleW-1:0];
        REG_MODE_BITS:  cfg_r.mode_bits  <= cfg_data[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: output register frees up when empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_beat) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  pidfd_terms u_terms (
    .setpoint (sp_r),
    .feedback (fb_r),
    .cfg      (cfg_r),
    .st       (st_r),
    .terms    (terms)
  );

  pidfd_clamp u_clamp (
    .terms   (terms),
    .out_min (cfg_r.out_min),
    .out_max (cfg_r.out_max),
    .drive   (drive),
    .clamped (clamped)
  );

  always_comb begin
    st_nxt = st_r;
    if (advance) begin
      st_nxt.prev_error   = terms.err;
      st_nxt.integ_term   = terms.i_term;
      st_nxt.deriv_term   = terms.d_term;
      st_nxt.last_clamped = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      sp_r <= in_tdata[SampleW-1:0];
      fb_r <= in_tdata[2*SampleW-1:SampleW];
    end
    if (advance) begin
      drive_r   <= drive;
      clamped_r <= clamped;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-SampleW-1){1'b0}}, clamped_r, drive_r};

endmodule
